FILE: design/des_pkg.sv
// DES package: permutation tables, S-box lookup, round key schedule helpers.
// Used by des_round_cell, des_key_sched and des_block_cipher.
package des_pkg;

  localparam int Rounds = 16;

  typedef logic [47:0] subkey_t;

  typedef struct packed {
    logic       valid;
    logic       decrypt;
    logic       last;
    logic [31:0] lh;
    logic [31:0] rh;
  } round_t;

  typedef logic [6:0] tab_t [64];

  localparam tab_t TabIp = '{
    7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2,7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,7'd12,7'd4,
    7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6,7'd64,7'd56,7'd48,7'd40,7'd32,7'd24,7'd16,7'd8,
    7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
    7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7};
  localparam tab_t TabFp = '{
    7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32,7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,7'd63,7'd31,
    7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30,7'd37,7'd5,7'd45,7'd13,7'd53,7'd21,7'd61,7'd29,
    7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28,7'd35,7'd3,7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,
    7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26,7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25};
  localparam logic [5:0] TabE [48] = '{
    6'd32,6'd1,6'd2,6'd3,6'd4,6'd5,6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,6'd8,6'd9,6'd10,6'd11,
    6'd12,6'd13,6'd12,6'd13,6'd14,6'd15,6'd16,6'd17,6'd16,6'd17,6'd18,6'd19,6'd20,6'd21,
    6'd20,6'd21,6'd22,6'd23,6'd24,6'd25,6'd24,6'd25,6'd26,6'd27,6'd28,6'd29,6'd28,6'd29,
    6'd30,6'd31,6'd32,6'd1};
  localparam logic [5:0] TabP [32] = '{
    6'd16,6'd7,6'd20,6'd21,6'd29,6'd12,6'd28,6'd17,6'd1,6'd15,6'd23,6'd26,6'd5,6'd18,6'd31,
    6'd10,6'd2,6'd8,6'd24,6'd14,6'd32,6'd27,6'd3,6'd9,6'd19,6'd13,6'd30,6'd6,6'd22,6'd11,
    6'd4,6'd25};
  localparam logic [5:0] TabPc1 [56] = '{
    6'd57,6'd49,6'd41,6'd33,6'd25,6'd17,6'd9,6'd1,6'd58,6'd50,6'd42,6'd34,6'd26,6'd18,
    6'd10,6'd2,6'd59,6'd51,6'd43,6'd35,6'd27,6'd19,6'd11,6'd3,6'd60,6'd52,6'd44,6'd36,
    6'd63,6'd55,6'd47,6'd39,6'd31,6'd23,6'd15,6'd7,6'd62,6'd54,6'd46,6'd38,6'd30,6'd22,
    6'd14,6'd6,6'd61,6'd53,6'd45,6'd37,6'd29,6'd21,6'd13,6'd5,6'd28,6'd20,6'd12,6'd4};
  localparam logic [5:0] TabPc2 [48] = '{
    6'd14,6'd17,6'd11,6'd24,6'd1,6'd5,6'd3,6'd28,6'd15,6'd6,6'd21,6'd10,6'd23,6'd19,6'd12,
    6'd4,6'd26,6'd8,6'd16,6'd7,6'd27,6'd20,6'd13,6'd2,6'd41,6'd52,6'd31,6'd37,6'd47,6'd55,
    6'd30,6'd40,6'd51,6'd45,6'd33,6'd48,6'd44,6'd49,6'd39,6'd56,6'd34,6'd53,6'd46,6'd42,
    6'd50,6'd36,6'd29,6'd32};
  localparam logic [1:0] TabShift [16] = '{
    2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1};
  localparam logic [3:0] TabS [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  function automatic logic [63:0] perm64(input logic [63:0] x, input tab_t tab);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[i] = x[6'(tab[i] - 7'd1)];
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] rh, input subkey_t k);
    logic [47:0] e;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    logic [3:0]  v;
    for (int i = 0; i < 48; i++) e[i] = rh[5'(TabE[i] - 6'd1)];
    e = e ^ k;
    for (int g = 0; g < 8; g++) begin
      six = e[6*g +: 6];
      v = TabS[g][{six[0], six[5], six[1], six[2], six[3], six[4]}];
      s[4*g +: 4] = {v[0], v[1], v[2], v[3]};
    end
    for (int i = 0; i < 32; i++) p[i] = s[5'(TabP[i] - 6'd1)];
    return p;
  endfunction

  function automatic logic [55:0] pc1(input logic [63:0] key);
    logic [55:0] t;
    for (int i = 0; i < 56; i++) t[i] = key[TabPc1[i] - 6'd1];
    return t;
  endfunction

  function automatic subkey_t pc2(input logic [55:0] cd);
    subkey_t k;
    for (int i = 0; i < 48; i++) k[i] = cd[TabPc2[i] - 6'd1];
    return k;
  endfunction

  // Right rotate of a 28-bit half by 1 or 2.
  function automatic logic [27:0] rot28(input logic [27:0] x, input logic [1:0] s);
    return (s == 2'd2) ? {x[1:0], x[27:2]} : {x[0], x[27:1]};
  endfunction

endpackage

FILE: design/des_key_sched.sv
// DES key schedule: holds PC-1 of the key and wires out the 16 derived subkeys.
// Depends on des_pkg. Subkeys follow a key write from the next cycle on.
module des_key_sched (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 key_we,
  input  logic [63:0]          key_data,
  output des_pkg::subkey_t     subkeys [16]
);
  logic [55:0] cd_r;
  logic [55:0] cd [17];

  // Hold PC-1 of the key; the rotated halves of each round are plain wiring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r <= des_pkg::pc1(64'd0);
    end else if (key_we) begin
      cd_r <= des_pkg::pc1(key_data);
    end
  end

  assign cd[0] = cd_r;

  for (genvar r = 0; r < 16; r++) begin : g_step
    assign cd[r+1] = {des_pkg::rot28(cd[r][55:28], des_pkg::TabShift[r]),
                      des_pkg::rot28(cd[r][27:0], des_pkg::TabShift[r])};
    assign subkeys[r] = des_pkg::pc2(cd[r+1]);
  end
endmodule

FILE: design/des_round_cell.sv
// One Feistel round cell of the DES pipeline.
// Depends on des_pkg. Holds one block in flight and hands it on each cycle it advances.
module des_round_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              swap,
  input  des_pkg::subkey_t  key_enc,
  input  des_pkg::subkey_t  key_dec,
  input  des_pkg::round_t   cell_in,
  output des_pkg::round_t   cell_out
);
  des_pkg::round_t st_r;
  des_pkg::round_t st_nxt;
  logic [31:0]     lx;

  always_comb begin
    lx = cell_in.lh ^ des_pkg::feistel(cell_in.rh,
                                       cell_in.decrypt ? key_dec : key_enc);
    st_nxt = cell_in;
    if (swap) begin
      st_nxt.lh = cell_in.rh;
      st_nxt.rh = lx;
    end else begin
      st_nxt.lh = lx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign cell_out = st_r;
endmodule

FILE: design/des_block_cipher.sv
// DES ECB top level: padding, IP, a chain of 16 round cells, FP and pad check.
// Path: entry register, 16 round cells and output register, all stalled together.
// Throughput: one block per cycle; the whole chain advances when the output is free.
// Reset: synchronous active-low rst_n clears all valid bits and loads the all-zero key.
// A key write changes the subkeys of every round cell, also for blocks in flight.
module des_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_cipher_key,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [63:0] in_data_block,
  input  logic [3:0]  in_byte_count,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_out_block,
  output logic [3:0]  out_kept_bytes
);
  des_pkg::subkey_t subkeys [16];
  des_pkg::round_t  chain [17];
  des_pkg::round_t  entry_nxt;
  des_pkg::round_t  entry_r;
  logic             advance;
  logic [63:0]      blk;
  logic [63:0]      ip_out;
  logic [63:0]      plain;
  logic [7:0]       pad;
  logic [3:0]       kept_nxt;
  logic             out_valid_r;
  logic [63:0]      out_block_r;
  logic [3:0]       kept_r;

  des_key_sched u_keys (
    .clk      (clk),
    .rst_n    (rst_n),
    .key_we   (cfg_we),
    .key_data (cfg_cipher_key),
    .subkeys  (subkeys)
  );

  // Whole chain moves when the output register is free or being drained.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  always_comb begin
    blk = in_data_block;
    if (!in_action && in_byte_count >= 4'd1 && in_byte_count <= 4'd7) begin
      for (int j = 0; j < 8; j++) begin
        if (4'(j) >= in_byte_count) blk[8*j +: 8] = 8'd0;
      end
      blk[63:56] = 8'd8 - {4'd0, in_byte_count};
    end
    ip_out = des_pkg::perm64(blk, des_pkg::TabIp);
    entry_nxt.valid   = in_valid;
    entry_nxt.decrypt = in_action;
    entry_nxt.last    = in_is_last;
    entry_nxt.lh      = ip_out[31:0];
    entry_nxt.rh      = ip_out[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (advance) begin
      entry_r <= entry_nxt;
    end
  end
  assign chain[0] = entry_r;

  for (genvar r = 0; r < 16; r++) begin : g_round
    des_round_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .swap     (r != 15),
      .key_enc  (subkeys[r]),
      .key_dec  (subkeys[15-r]),
      .cell_in  (chain[r]),
      .cell_out (chain[r+1])
    );
  end

  always_comb begin
    plain    = des_pkg::perm64({chain[16].rh, chain[16].lh}, des_pkg::TabFp);
    pad      = plain[63:56];
    kept_nxt = 4'd8;
    if (chain[16].decrypt && chain[16].last && pad >= 8'd1 && pad <= 8'd7) begin
      kept_nxt = 4'd8 - pad[3:0];
      for (int j = 0; j < 7; j++) begin
        if (4'(j) >= 4'd8 - pad[3:0] && plain[8*j +: 8] != 8'd0) kept_nxt = 4'd8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= chain[16].valid;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      out_block_r <= plain;
      kept_r      <= kept_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_out_block  = out_block_r;
  assign out_kept_bytes = kept_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_block_r))
    else $error("output changed while stalled");
  a_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> kept_r >= 4'd1 && kept_r <= 4'd8)
    else $error("kept byte count out of range");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without output back-pressure");
endmodule

FILE: test/tb_top.sv
// Testbench for des_block_cipher: directed table then random blocks, checked
// against an in-bench DES predictor. Depends on des_pkg for round count only.
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic {ActEncrypt = 1'b0, ActDecrypt = 1'b1} action_t;

  typedef struct packed {
    logic [63:0] blk;
    logic [3:0]  kept;
  } cipher_result_t;

  typedef struct {
    action_t     act;
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        known;
    logic [3:0]  kept;
  } stim_row_t;

  localparam int KeySettle = 40;
  localparam int WatchLimit = 5000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [63:0] cfg_cipher_key;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [63:0] in_data_block;
  logic [3:0]  in_byte_count;
  logic        in_is_last;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_out_block;
  logic [3:0]  out_kept_bytes;

  des_block_cipher dut (.*);

  int ip_t[64] = '{58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
    64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,61,53,45,37,29,21,
    13,5,63,55,47,39,31,23,15,7};
  int fp_t[64] = '{40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
    37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,34,2,42,10,50,18,
    58,26,33,1,41,9,49,17,57,25};
  int e_t[48] = '{32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,16,17,18,19,
    20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  int p_t[32] = '{16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,2,8,24,14,32,27,3,9,19,13,
    30,6,22,11,4,25};
  int pc1_t[56] = '{57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,
    20,12,4};
  int pc2_t[48] = '{14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,41,52,
    31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  int shift_t[16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  int sbox_t[8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  logic [47:0]    subkeys[des_pkg::Rounds];
  cipher_result_t pending_results[$];
  int             fail_count;
  int             idle_cycles;
  bit             quiet_phase;

  function automatic logic [63:0] bit_select(logic [63:0] x, int n, int tab[]);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r[i] = x[tab[i] - 1];
    return r;
  endfunction

  task automatic load_subkeys(logic [63:0] key);
    logic [55:0] t;
    logic [27:0] c, d;
    logic [55:0] cd;
    t = 56'(bit_select(key, 56, pc1_t));
    c = t[27:0];
    d = t[55:28];
    for (int r = 0; r < des_pkg::Rounds; r++) begin
      for (int s = 0; s < shift_t[r]; s++) begin
        c = {c[0], c[27:1]};
        d = {d[0], d[27:1]};
      end
      cd = {d, c};
      subkeys[r] = 48'(bit_select({8'h0, cd}, 48, pc2_t));
    end
  endtask

  function automatic logic [31:0] round_mix(logic [31:0] rh, logic [47:0] k);
    logic [47:0] e;
    logic [31:0] s;
    logic [5:0]  six;
    int          v;
    e = 48'(bit_select({32'h0, rh}, 48, e_t)) ^ k;
    for (int g = 0; g < 8; g++) begin
      six = e[6*g +: 6];
      v = sbox_t[g][{six[0], six[5], six[1], six[2], six[3], six[4]}];
      s[4*g +: 4] = {v[0], v[1], v[2], v[3]};
    end
    return 32'(bit_select({32'h0, s}, 32, p_t));
  endfunction

  function automatic logic [63:0] des_crypt(logic [63:0] blk, bit dec);
    logic [63:0] x;
    logic [31:0] lh, rh, t;
    x = bit_select(blk, 64, ip_t);
    lh = x[31:0];
    rh = x[63:32];
    for (int i = 0; i < des_pkg::Rounds; i++) begin
      lh ^= round_mix(rh, subkeys[dec ? des_pkg::Rounds - 1 - i : i]);
      if (i != des_pkg::Rounds - 1) begin
        t = lh; lh = rh; rh = t;
      end
    end
    return bit_select({rh, lh}, 64, fp_t);
  endfunction

  function automatic cipher_result_t predict_block(action_t act, logic [63:0] data,
                                                   logic [3:0] count, logic last);
    cipher_result_t res;
    logic [63:0]    blk;
    int             pad;
    bit             ok;
    res.kept = 4'd8;
    blk = data;
    if (act == ActEncrypt) begin
      if (count >= 1 && count <= 7) begin
        blk &= (64'd1 << (8 * count)) - 64'd1;
        blk |= 64'(8 - count) << 56;
      end
      res.blk = des_crypt(blk, 1'b0);
    end else begin
      res.blk = des_crypt(blk, 1'b1);
      pad = res.blk[63:56];
      if (last && pad >= 1 && pad <= 7) begin
        ok = 1'b1;
        for (int j = 8 - pad; j < 7; j++) if (res.blk[8*j +: 8] != 8'h0) ok = 1'b0;
        if (ok) res.kept = 4'(8 - pad);
      end
    end
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stall, compare each transfer with the oldest prediction.
  always @(posedge clk) begin
    cipher_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result block %h", out_out_block);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_out_block !== want.blk) begin
            $error("out_block expected %h actual %h", want.blk, out_out_block);
            fail_count++;
          end
          if (out_kept_bytes !== want.kept) begin
            $error("kept_bytes expected %0d actual %0d", want.kept, out_kept_bytes);
            fail_count++;
          end
        end
      end
      out_stall <= quiet_phase ? 1'b0 : ($urandom_range(99) < 18);
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic send_block(action_t act, logic [63:0] data, logic [3:0] count,
                            logic last);
    while (!quiet_phase && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_data_block <= data;
    in_byte_count <= count;
    in_is_last    <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_block(act, data, count, last));
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (KeySettle) @(posedge clk);
  endtask

  task automatic write_key(logic [63:0] key);
    cfg_we         <= 1'b1;
    cfg_cipher_key <= key;
    @(posedge clk);
    cfg_we <= 1'b0;
    load_subkeys(key);
    repeat (KeySettle) @(posedge clk);
  endtask

  // Random blocks; in some pairs an encrypted tail is decrypted as last.
  task automatic random_phase(int count_items);
    logic [63:0] data;
    logic [3:0]  n;
    cipher_result_t enc;
    for (int i = 0; i < count_items; i++) begin
      data = {$urandom, $urandom};
      n = 4'($urandom_range(15));
      case ($urandom_range(3))
        0: begin
          enc = predict_block(ActEncrypt, data, n, 1'b0);
          send_block(ActEncrypt, data, n, 1'($urandom_range(1)));
          send_block(ActDecrypt, enc.blk, 4'($urandom_range(15)), 1'b1);
          i++;
        end
        1: send_block(ActEncrypt, data, n, 1'($urandom_range(1)));
        default: send_block(ActDecrypt, data, n, 1'($urandom_range(1)));
      endcase
    end
  endtask

  stim_row_t      directed[$];
  logic [63:0]    zero_enc;
  cipher_result_t scratch_res;

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_cipher_key = '0;
    in_valid = 1'b0;
    in_action = 1'b0;
    in_data_block = '0;
    in_byte_count = 4'd8;
    in_is_last = 1'b0;
    fail_count = 0;
    quiet_phase = 1'b0;
    load_subkeys(64'h0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (KeySettle) @(posedge clk);

    scratch_res = predict_block(ActEncrypt, 64'h0, 4'd8, 1'b0);
    zero_enc = scratch_res.blk;
    directed = '{
      '{ActEncrypt, 64'h0, 4'd8, 1'b0, 1'b0, 4'd8},
      '{ActEncrypt, '1, 4'd8, 1'b0, 1'b0, 4'd8},
      '{ActDecrypt, zero_enc, 4'd8, 1'b1, 1'b1, 4'd8},
      '{ActDecrypt, '1, 4'd0, 1'b0, 1'b1, 4'd8},
      '{ActEncrypt, '1, 4'd1, 1'b0, 1'b0, 4'd8},
      '{ActEncrypt, '1, 4'd7, 1'b0, 1'b0, 4'd8},
      '{ActEncrypt, '1, 4'd0, 1'b1, 1'b0, 4'd8},
      '{ActEncrypt, '1, 4'd9, 1'b0, 1'b0, 4'd8},
      '{ActEncrypt, '1, 4'd15, 1'b0, 1'b0, 4'd8},
      '{ActEncrypt, 64'h0123456789abcdef, 4'd4, 1'b0, 1'b0, 4'd8},
      '{ActDecrypt, 64'h0123456789abcdef, 4'd3, 1'b1, 1'b0, 4'd8},
      '{ActDecrypt, 64'hfedcba9876543210, 4'd15, 1'b0, 1'b1, 4'd8}};
    foreach (directed[i]) begin
      send_block(directed[i].act, directed[i].data, directed[i].count, directed[i].last);
      if (directed[i].known) pending_results[$].kept = directed[i].kept;
    end
    // Round trips of short tails: decrypt of each must report the kept count.
    for (int n = 1; n <= 7; n++) begin
      scratch_res = predict_block(ActEncrypt, 64'h1122334455667788, 4'(n), 1'b0);
      send_block(ActDecrypt, scratch_res.blk, 4'd8, 1'b1);
      if (pending_results[$].kept !== 4'(n)) begin
        $error("kept_bytes predictor expected %0d actual %0d", n, pending_results[$].kept);
        fail_count++;
      end
    end
    drain_and_idle();

    write_key('1);
    random_phase(250);
    // Hold the sender until every result is back.
    drain_and_idle();
    write_key({$urandom, $urandom});
    quiet_phase = 1'b1;
    random_phase(200);
    quiet_phase = 1'b0;
    drain_and_idle();
    write_key(64'h0);
    random_phase(250);
    drain_and_idle();
    write_key({$urandom, $urandom});
    random_phase(330);
    drain_and_idle();

    if (fail_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
